[src/assert_macros.svh]
// Assertion macros used by the top level of the timer slot bank
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, masked while in reset
`define TSB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer slot bank check failed");

// Next-cycle implication, sampled on clk, masked while in reset
`define TSB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer slot bank check failed");

`endif

[src/tsb_pkg.sv]
// Types, codes and defaults for the timer slot bank
package tsb_pkg;

    // Defaults
    localparam int          SLOTS_DEF      = 16;
    localparam logic [31:0] MIN_PERIOD_RST = 32'd1000;
    localparam int          CMD_DEPTH      = 2;
    localparam int          RES_DEPTH      = 4;

    // Register index of min_period
    localparam logic        REG_MIN_PERIOD = 1'b0;

    // Opcodes
    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_CANCEL  = 3'd1;
    localparam logic [2:0] OP_POLL    = 3'd2;
    localparam logic [2:0] OP_DESTROY = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_INVAL  = 2'd1;
    localparam logic [1:0] ST_NOFREE = 2'd2;

    // Wait states
    localparam logic [1:0] WS_PENDING  = 2'd0;
    localparam logic [1:0] WS_FIRED    = 2'd1;
    localparam logic [1:0] WS_CANCELED = 2'd2;

    // Result kinds
    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_NOTIFY = 1'b1;

    // Classified command, front to back
    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  idx;
        logic [63:0] now;
        logic [63:0] dl_init;   // now + delay, saturated
        logic [63:0] per;
        logic        bad_per;   // nonzero period below minimum
    } cmd_t;

    // One result beat
    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [5:0] slot;
        logic [1:0] ws;
        logic       last;
    } res_t;

endpackage

[src/tsb_queue.sv]
// Small register-based FIFO used for the command and result queues
module tsb_queue
    import tsb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/tsb_front.sv]
// Front end: takes input beats, works out the create deadline and period check
module tsb_front
    import tsb_pkg::*;
(
    input  logic        push,
    input  logic [2:0]  opcode,
    input  logic [5:0]  slot_index,
    input  logic [63:0] now_time,
    input  logic [63:0] delay_ticks,
    input  logic [63:0] period_ticks,
    input  logic [31:0] min_period,
    input  logic        cmd_full,
    output logic        cmd_push,
    output cmd_t        cmd
);

    logic [64:0] dl_sum;

    // Saturating now + delay
    assign dl_sum = {1'b0, now_time} + {1'b0, delay_ticks};

    always_comb
    begin
        cmd.op      = opcode;
        cmd.idx     = slot_index;
        cmd.now     = now_time;
        cmd.dl_init = dl_sum[64] ? '1 : dl_sum[63:0];
        cmd.per     = period_ticks;
        cmd.bad_per = (period_ticks != '0) && (period_ticks < {32'd0, min_period});
    end

    assign cmd_push = push && !cmd_full;

endmodule

[src/tsb_back.sv]
// Back end: slot state, walks the slots for poll and create, emits result beats
module tsb_back
    import tsb_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  logic cmd_empty,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_POLL   = 2'd1;
    localparam logic [1:0] S_REPLY  = 2'd2;
    localparam logic [1:0] S_CREATE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic [SLOTS-1:0] canc_reg, canc_next;
    logic [SLOTS-1:0] fired_reg, fired_next;
    logic [63:0]      deadline_mem [SLOTS];
    logic [63:0]      period_mem [SLOTS];

    logic             dl_we, per_we;
    logic [IDX_W-1:0] wr_idx;
    logic [63:0]      dl_wdata;

    logic [IDX_W-1:0] idx_l;
    logic             slot_ok;
    logic             last_slot;
    logic [63:0]      cur_dl, cur_per, diff;
    logic [64:0]      reload;
    logic             due;

    assign idx_l     = cmd.idx[IDX_W-1:0];
    assign slot_ok   = (cmd.idx < 6'(SLOTS)) && used_reg[idx_l];
    assign last_slot = (cnt_reg == IDX_W'(SLOTS - 1));

    // Slot under the walk pointer: expiry test and saturating reload
    assign cur_dl  = deadline_mem[cnt_reg];
    assign cur_per = period_mem[cnt_reg];
    assign diff    = cmd.now - cur_dl;
    assign due     = !diff[63];
    assign reload  = {1'b0, cur_dl} + {1'b0, cur_per};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        used_next  = used_reg;
        canc_next  = canc_reg;
        fired_next = fired_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res        = '0;
        res.last   = 1'b1;
        dl_we      = 1'b0;
        per_we     = 1'b0;
        wr_idx     = cnt_reg;
        dl_wdata   = cmd.dl_init;

        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    case (cmd.op)
                        OP_CREATE:
                        begin
                            if (cmd.bad_per)
                            begin
                                res_push   = 1'b1;
                                res.status = ST_INVAL;
                                cmd_pop    = 1'b1;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                state_next = S_CREATE;
                            end
                        end
                        OP_POLL:
                        begin
                            cnt_next   = '0;
                            state_next = S_POLL;
                        end
                        OP_CANCEL, OP_DESTROY, OP_QUERY:
                        begin
                            res_push = 1'b1;
                            cmd_pop  = 1'b1;
                            res.slot = cmd.idx;
                            if (!slot_ok)
                            begin
                                res.status = ST_INVAL;
                            end
                            else if (cmd.op == OP_CANCEL)
                            begin
                                canc_next[idx_l] = 1'b1;
                            end
                            else if (cmd.op == OP_DESTROY)
                            begin
                                used_next[idx_l]  = 1'b0;
                                canc_next[idx_l]  = 1'b0;
                                fired_next[idx_l] = 1'b0;
                            end
                            else
                            begin
                                res.ws = canc_reg[idx_l]  ? WS_CANCELED :
                                         fired_reg[idx_l] ? WS_FIRED : WS_PENDING;
                            end
                        end
                        default:
                        begin
                            res_push   = 1'b1;
                            res.status = ST_INVAL;
                            cmd_pop    = 1'b1;
                        end
                    endcase
                end
            end

            // One slot a cycle while the result queue has room; notify in slot order
            S_POLL:
            begin
                if (!res_full)
                begin
                    if (used_reg[cnt_reg] && !canc_reg[cnt_reg] && due)
                    begin
                        fired_next[cnt_reg] = 1'b1;
                        dl_we    = (cur_per != '0);
                        dl_wdata = reload[64] ? '1 : reload[63:0];
                        res_push = 1'b1;
                        res.kind = KIND_NOTIFY;
                        res.slot = 6'(cnt_reg);
                        res.ws   = WS_FIRED;
                        res.last = 1'b0;
                    end
                    if (last_slot)
                    begin
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            // Closing reply of a poll
            S_REPLY:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    cmd_pop    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // Search for the lowest free slot
            S_CREATE:
            begin
                if (!res_full)
                begin
                    if (!used_reg[cnt_reg])
                    begin
                        used_next[cnt_reg]  = 1'b1;
                        canc_next[cnt_reg]  = 1'b0;
                        fired_next[cnt_reg] = 1'b0;
                        dl_we      = 1'b1;
                        per_we     = 1'b1;
                        res_push   = 1'b1;
                        res.slot   = 6'(cnt_reg);
                        cmd_pop    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (last_slot)
                    begin
                        res_push   = 1'b1;
                        res.status = ST_NOFREE;
                        cmd_pop    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            used_reg  <= '0;
            canc_reg  <= '0;
            fired_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            used_reg  <= used_next;
            canc_reg  <= canc_next;
            fired_reg <= fired_next;
        end
    end

    // Deadline and period storage, written only at create and reload
    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            deadline_mem[wr_idx] <= dl_wdata;
        end
        if (per_we)
        begin
            period_mem[wr_idx] <= cmd.per;
        end
    end

endmodule

[src/timer_slot_bank_top.sv]
// Top level of the timer slot bank: APB register, queues, front and back ends
//
// Usage: a bank of timer slots driven by one opcode per input beat.
// Input channel: present a beat and raise push; it is taken on a rising edge
// with push high and full low. Results come out as a queue: while empty is
// low the oldest result beat sits on the result ports, and pop on a rising
// edge takes it. Each input gives one reply beat marked last_of_run; poll
// puts its expiry notifications first, in slot order.
// An accepted item is registered in the command queue before the back end
// sees it. Cancel, destroy, query and a refused create are answered from the
// idle state. Create leaves the idle state, then walks to the lowest free
// slot; poll checks each slot in turn, then sends its reply. The back end
// finishes one item before it takes the next.
// The command queue holds two items, the result queue four beats. When the
// receiver stalls the back end waits on a full result queue and the input
// shows full once the command queue fills; nothing is dropped.
// Reset clears all slots, both queues and sets min_period to 1000.
// min_period sits at APB address 0; write it only while the block is idle.
module timer_slot_bank_top
    import tsb_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        push,
    output logic        full,
    input  logic [2:0]  opcode,
    input  logic [5:0]  slot_index,
    input  logic [63:0] now_time,
    input  logic [63:0] delay_ticks,
    input  logic [63:0] period_ticks,
    // Result channel
    output logic        empty,
    input  logic        pop,
    output logic        result_kind,
    output logic [1:0]  status,
    output logic [5:0]  result_slot,
    output logic [1:0]  wait_state,
    output logic        last_of_run
);

`include "assert_macros.svh"

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(res_t);

    logic [31:0] min_period_reg;
    logic        cfg_wr;

    cmd_t cmd_in, cmd_head;
    logic cmd_push, cmd_pop, cmd_full, cmd_empty;
    res_t res_in, res_head;
    logic res_push, res_full;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MIN_PERIOD);
    assign prdata = (paddr[2] == REG_MIN_PERIOD) ? min_period_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg <= MIN_PERIOD_RST;
        end
        else if (cfg_wr)
        begin
            min_period_reg <= pwdata;
        end
    end

    // Front end
    tsb_front u_front (
        .push         (push),
        .opcode       (opcode),
        .slot_index   (slot_index),
        .now_time     (now_time),
        .delay_ticks  (delay_ticks),
        .period_ticks (period_ticks),
        .min_period   (min_period_reg),
        .cmd_full     (cmd_full),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    assign full = cmd_full;

    // Command queue between the front and back ends
    tsb_queue #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    // Back end
    tsb_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // Result queue
    tsb_queue #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_head),
        .full    (res_full),
        .empty   (empty)
    );

    assign result_kind = res_head.kind;
    assign status      = res_head.status;
    assign result_slot = res_head.slot;
    assign wait_state  = res_head.ws;
    assign last_of_run = res_head.last;

    // Checks
    `TSB_ASSERT_NOW(a_no_push_full, res_push, !res_full)
    `TSB_ASSERT_NOW(a_pop_has_cmd, cmd_pop, !cmd_empty && res_push)
    `TSB_ASSERT_NOW(a_notify_not_last, res_push && (res_in.kind == KIND_NOTIFY),
                    !res_in.last && (res_in.status == ST_OK))

endmodule

[verif/timer_slot_bank_top_test.sv]
// Self-checking testbench for the timer slot bank: directed and random opcode traffic
`timescale 1ns / 100ps

module timer_slot_bank_top_test;
    import tsb_pkg::*;

    localparam int          SLOT_COUNT  = SLOTS_DEF;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam logic [2:0]  REG_ADDR_MIN_PERIOD = {REG_MIN_PERIOD, 2'b00};

    // One input beat as the sender builds it
    typedef struct {
        logic [2:0]  op;
        logic [5:0]  idx;
        logic [63:0] now;
        logic [63:0] dly;
        logic [63:0] per;
    } timer_cmd_t;

    // Clock, reset and block ports
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push         = 1'b0;
    logic        full;
    logic [2:0]  opcode       = '0;
    logic [5:0]  slot_index   = '0;
    logic [63:0] now_time     = '0;
    logic [63:0] delay_ticks  = '0;
    logic [63:0] period_ticks = '0;
    logic        empty;
    logic        pop          = 1'b0;
    logic        result_kind;
    logic [1:0]  status;
    logic [5:0]  result_slot;
    logic [1:0]  wait_state;
    logic        last_of_run;

    // Predicted slot bank state
    bit          mdl_used     [SLOT_COUNT];
    bit          mdl_canceled [SLOT_COUNT];
    bit          mdl_fired    [SLOT_COUNT];
    logic [63:0] mdl_deadline [SLOT_COUNT];
    logic [63:0] mdl_period   [SLOT_COUNT];
    logic [31:0] mdl_min_period = MIN_PERIOD_RST;

    // Result beats still owed by the block, oldest first
    res_t        owed_beats [$];

    // Traffic shaping and bookkeeping
    int          send_gap_pct  = 0;
    int          recv_gap_pct  = 0;
    int          hold_request  = 0;
    int          errors        = 0;
    int          items_sent    = 0;
    int          beats_seen    = 0;
    int          notes_seen    = 0;
    int          cycle_count   = 0;
    logic [63:0] tick_now      = '0;

    timer_slot_bank_top #(.SLOTS(SLOT_COUNT)) dut (.*);

    initial forever #5 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles, %0d beats still owed",
                 $time, cycle_count, owed_beats.size());
        $display("FAILURE");
        $finish;
    end

    // Saturating 64-bit add
    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic res_t make_beat(input logic kind, input logic [1:0] st,
                                       input logic [5:0] slot, input logic [1:0] ws,
                                       input logic last);
        res_t r;
        r.kind   = kind;
        r.status = st;
        r.slot   = slot;
        r.ws     = ws;
        r.last   = last;
        return r;
    endfunction

    function automatic timer_cmd_t make_cmd(input logic [2:0] op, input logic [5:0] idx,
                                            input logic [63:0] now, input logic [63:0] dly,
                                            input logic [63:0] per);
        timer_cmd_t c;
        c.op  = op;
        c.idx = idx;
        c.now = now;
        c.dly = dly;
        c.per = per;
        return c;
    endfunction

    // Apply one accepted beat to the slot bank and queue the beats it owes
    function automatic void advance_slots(input timer_cmd_t c);
        int          free_slot;
        logic        hit;
        logic [63:0] lag;
        free_slot = -1;
        hit = (c.idx < SLOT_COUNT) && mdl_used[c.idx];
        case (c.op)
            OP_CREATE:
            begin
                if (c.per != 0 && c.per < {32'd0, mdl_min_period})
                    owed_beats.push_back(make_beat(KIND_REPLY, ST_INVAL, 0, WS_PENDING, 1'b1));
                else
                begin
                    for (int i = SLOT_COUNT - 1; i >= 0; i--)
                        if (!mdl_used[i])
                            free_slot = i;
                    if (free_slot < 0)
                        owed_beats.push_back(make_beat(KIND_REPLY, ST_NOFREE, 0,
                                                       WS_PENDING, 1'b1));
                    else
                    begin
                        mdl_used[free_slot]     = 1'b1;
                        mdl_canceled[free_slot] = 1'b0;
                        mdl_fired[free_slot]    = 1'b0;
                        mdl_deadline[free_slot] = sat_sum(c.now, c.dly);
                        mdl_period[free_slot]   = c.per;
                        owed_beats.push_back(make_beat(KIND_REPLY, ST_OK, 6'(free_slot),
                                                       WS_PENDING, 1'b1));
                    end
                end
            end
            OP_CANCEL:
            begin
                if (hit)
                    mdl_canceled[c.idx] = 1'b1;
                owed_beats.push_back(make_beat(KIND_REPLY, hit ? ST_OK : ST_INVAL, c.idx,
                                               WS_PENDING, 1'b1));
            end
            OP_POLL:
            begin
                // walk upward; signed now - deadline >= 0 means expired
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    lag = c.now - mdl_deadline[i];
                    if (mdl_used[i] && !mdl_canceled[i] && !lag[63])
                    begin
                        mdl_fired[i] = 1'b1;
                        if (mdl_period[i] != 0)
                            mdl_deadline[i] = sat_sum(mdl_deadline[i], mdl_period[i]);
                        owed_beats.push_back(make_beat(KIND_NOTIFY, ST_OK, 6'(i),
                                                       WS_FIRED, 1'b0));
                    end
                end
                owed_beats.push_back(make_beat(KIND_REPLY, ST_OK, 0, WS_PENDING, 1'b1));
            end
            OP_DESTROY:
            begin
                if (hit)
                begin
                    mdl_used[c.idx]     = 1'b0;
                    mdl_canceled[c.idx] = 1'b0;
                    mdl_fired[c.idx]    = 1'b0;
                end
                owed_beats.push_back(make_beat(KIND_REPLY, hit ? ST_OK : ST_INVAL, c.idx,
                                               WS_PENDING, 1'b1));
            end
            OP_QUERY:
            begin
                if (!hit)
                    owed_beats.push_back(make_beat(KIND_REPLY, ST_INVAL, c.idx,
                                                   WS_PENDING, 1'b1));
                else
                    owed_beats.push_back(make_beat(KIND_REPLY, ST_OK, c.idx,
                                                   mdl_canceled[c.idx] ? WS_CANCELED :
                                                   mdl_fired[c.idx] ? WS_FIRED : WS_PENDING,
                                                   1'b1));
            end
            default:
                owed_beats.push_back(make_beat(KIND_REPLY, ST_INVAL, 0, WS_PENDING, 1'b1));
        endcase
    endfunction

    // Random beat: mostly live slots and a slowly advancing clock
    function automatic timer_cmd_t pick_item();
        timer_cmd_t c;
        int         roll;
        int         live [$];
        roll = $urandom_range(99);
        if (roll < 30)      c.op = OP_CREATE;
        else if (roll < 55) c.op = OP_POLL;
        else if (roll < 65) c.op = OP_CANCEL;
        else if (roll < 82) c.op = OP_DESTROY;
        else if (roll < 95) c.op = OP_QUERY;
        else                c.op = 3'($urandom_range(OP_QUERY + 1, 7));

        for (int i = 0; i < SLOT_COUNT; i++)
            if (mdl_used[i])
                live.push_back(i);
        if (live.size() != 0 && $urandom_range(3) != 0)
            c.idx = 6'(live[$urandom_range(live.size() - 1)]);
        else
            c.idx = 6'($urandom_range(63));

        // time mostly creeps; now and then it jumps or lands anywhere
        roll = $urandom_range(99);
        if (roll < 90)      tick_now = tick_now + $urandom_range(0, 600);
        else if (roll < 95) tick_now = tick_now + $urandom;
        else                tick_now = {$urandom, $urandom};
        c.now = tick_now;

        roll = $urandom_range(9);
        if (roll < 8)       c.dly = $urandom_range(0, 4000);
        else if (roll < 9)  c.dly = {$urandom, $urandom};
        else                c.dly = '1;

        case ($urandom_range(9))
            0, 1, 2, 3: c.per = '0;
            4:          c.per = $urandom_range(0, mdl_min_period);
            5:          c.per = {32'd0, mdl_min_period};
            6, 7, 8:    c.per = {32'd0, mdl_min_period} + $urandom_range(0, 3000);
            default:    c.per = {$urandom, $urandom};
        endcase
        return c;
    endfunction

    // Offer one beat, honouring the sender gap rate, and predict on acceptance
    task automatic send_item(input timer_cmd_t c);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        opcode       <= c.op;
        slot_index   <= c.idx;
        now_time     <= c.now;
        delay_ticks  <= c.dly;
        period_ticks <= c.per;
        do @(posedge clk); while (full);
        items_sent++;
        advance_slots(c);
    endtask

    // Stop offering and wait until every owed beat has come back
    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (owed_beats.size() != 0);
    endtask

    // APB access to min_period; a write also updates the prediction
    task automatic min_period_access(input logic wr, input logic [31:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_ADDR_MIN_PERIOD;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (wr)
            mdl_min_period = wdata;
        else if (prdata !== mdl_min_period)
        begin
            errors++;
            $display("%0t: min_period read mismatch, expected %h, got %h",
                     $time, mdl_min_period, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [5:0] want,
                                        input logic [5:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch on beat %0d, expected %0d, got %0d",
                     $time, name, beats_seen, want, got);
        end
    endfunction

    // Receiver: random pop gaps, long hold-offs on request, beat checking
    initial
    begin
        res_t want;
        int   hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (pop && !empty)
                begin
                    beats_seen++;
                    if (result_kind === KIND_NOTIFY)
                        notes_seen++;
                    if (owed_beats.size() == 0)
                    begin
                        errors++;
                        $display("%0t: result beat with nothing owed, kind %0d slot %0d",
                                 $time, result_kind, result_slot);
                    end
                    else
                    begin
                        want = owed_beats.pop_front();
                        check_field("result_kind", 6'(want.kind), 6'(result_kind));
                        check_field("status", 6'(want.status), 6'(status));
                        check_field("result_slot", want.slot, result_slot);
                        check_field("wait_state", 6'(want.ws), 6'(wait_state));
                        check_field("last_of_run", 6'(want.last), 6'(last_of_run));
                    end
                end
                if (hold_request > 0)
                begin
                    hold_left    = hold_request;
                    hold_request = 0;
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    pop <= 1'b0;
                end
                else
                    pop <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    // Reset value, write and read-back of min_period
    task automatic test_register_access();
        min_period_access(1'b0, '0);
        min_period_access(1'b1, 32'h5A5A_A5A5);
        min_period_access(1'b0, '0);
        min_period_access(1'b1, MIN_PERIOD_RST);
        min_period_access(1'b0, '0);
    endtask

    // Each opcode, field extremes and the corner cases, at min_period 1000
    task automatic test_directed_ops();
        send_gap_pct = 37;
        recv_gap_pct = 64;
        send_item(make_cmd(OP_CREATE, 0, 0, 0, 64'd999));      // period just under minimum
        send_item(make_cmd(OP_CREATE, 0, 0, 5, 0));            // one-shot in slot 0
        send_item(make_cmd(OP_CREATE, 0, 0, 100, 64'd1000));  // period at the minimum
        send_item(make_cmd(OP_CREATE, 0, '1, '1, '1));         // deadline saturates
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 0));             // pending
        send_item(make_cmd(OP_POLL, 0, 0, 0, 0));              // saturated slot wraps signed
        send_item(make_cmd(OP_POLL, 0, 200, 0, 0));
        send_item(make_cmd(OP_POLL, 0, 201, 0, 0));            // one-shot renotifies
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 0));             // fired
        send_item(make_cmd(OP_CANCEL, 1, 0, 0, 0));
        send_item(make_cmd(OP_CANCEL, 1, 0, 0, 0));            // cancel twice is fine
        send_item(make_cmd(OP_QUERY, 1, 0, 0, 0));             // canceled
        send_item(make_cmd(OP_POLL, 0, 5000, 0, 0));           // canceled slot stays quiet
        send_item(make_cmd(OP_CANCEL, 5, 0, 0, 0));            // unused slot
        send_item(make_cmd(OP_QUERY, 63, '1, '1, '1));         // index beyond the bank
        send_item(make_cmd(OP_DESTROY, 16, 0, 0, 0));
        send_item(make_cmd(OP_DESTROY, 1, 0, 0, 0));
        send_item(make_cmd(OP_CREATE, 0, 64'h8000_0000_0000_0000, 0, '1));
        send_item(make_cmd(OP_POLL, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0));
        send_item(make_cmd(OP_POLL, 0, '1, 0, 0));             // periodic reload saturates
        for (int k = OP_QUERY + 1; k < 8; k++)
            send_item(make_cmd(3'(k), '1, '1, '1, '1));        // unknown opcodes
        send_item(make_cmd(OP_DESTROY, 0, 0, 0, 0));
        send_item(make_cmd(OP_DESTROY, 2, 0, 0, 0));
        drain();
    endtask

    // Fill every slot, overflow the full bank, then free the whole bank
    task automatic test_bank_full();
        for (int k = 0; k <= SLOT_COUNT; k++)
            send_item(make_cmd(OP_CREATE, 0, tick_now, $urandom_range(0, 3000), 0));
        send_item(make_cmd(OP_POLL, 0, tick_now + 64'd1500, 0, 0));
        for (int k = 0; k < SLOT_COUNT; k++)
            send_item(make_cmd(OP_DESTROY, 6'(k), 0, 0, 0));
        drain();
    endtask

    // Random mix at one min_period and one pair of gap rates
    task automatic test_random_mix(input int n_items, input int send_pct, input int recv_pct,
                                   input logic [31:0] min_per);
        drain();
        min_period_access(1'b1, min_per);
        min_period_access(1'b0, '0);
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        repeat (n_items)
            send_item(pick_item());
        drain();
    endtask

    // Receiver holds off long enough to fill both queues, then a full pause
    task automatic test_backpressure();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_request = 400;
        for (int k = 0; k < 40; k++)
        begin
            send_item(k % 2 ? make_cmd(OP_POLL, 0, tick_now, 0, 0) : pick_item());
        end
        drain();
        repeat (20)
            send_item(pick_item());
        drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_directed_ops();
        test_bank_full();
        test_random_mix(128, 37, 64, 32'd0);
        test_random_mix(128, 64, 37, 32'hFFFF_FFFF);
        test_random_mix(128, 0, 0, 32'($urandom_range(1, 5000)));
        test_backpressure();
        drain();
        repeat (2 * SLOT_COUNT + 8) @(posedge clk);
        $display("Sent %0d opcodes across four min_period settings and three gap patterns,",
                 items_sent);
        $display("checked %0d result beats, %0d of them expiry notifications, %0d errors.",
                 beats_seen, notes_seen, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
